// File: rtl/core/hlm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlm_pkg
// Shared widths, codes and reset constants for the heartbeat liveness monitor.
// ----------------------------------------------------------------------------
package hlm_pkg;

  localparam int NODES   = 4;
  localparam int ID_W    = 11;
  localparam int TIME_W  = 32;
  localparam int MS_W    = 16;
  localparam int BYTE_W  = 8;
  localparam int OP_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Item opcodes
  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_FRAME = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_BASE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HB_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID_0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID_1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID_2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID_3 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 3'd7;

  localparam logic [BYTE_W-1:0] HB_CHECK_BYTE = 8'h22;
  localparam logic [MS_W-1:0]   TIMEOUT_RST   = 16'd1000;
  localparam logic [MS_W-1:0]   PERIOD_RST    = 16'd200;

  typedef logic [ID_W-1:0]   id_t;
  typedef logic [TIME_W-1:0] ms_t;

  typedef struct packed {
    logic send_request;
    id_t  send_id;
    logic query_stale;
    logic any_stale;
  } result_t;

endpackage

// File: rtl/core/hlm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlm_cmd_if / hlm_rsp_if
// Valid/ready channels carrying monitor items and monitor results.
// ----------------------------------------------------------------------------
interface hlm_cmd_if import hlm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [ID_W-1:0]   frame_id;
  logic [BYTE_W-1:0] first_byte;
  logic [ID_W-1:0]   query_base;

  modport source (output valid, op, frame_id, first_byte, query_base, input ready);
  modport sink   (input valid, op, frame_id, first_byte, query_base, output ready);
endinterface

interface hlm_rsp_if import hlm_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            send_request;
  logic [ID_W-1:0] send_id;
  logic            query_stale;
  logic            any_stale;

  modport source (output valid, send_request, send_id, query_stale, any_stale,
                  input ready);
  modport sink   (input valid, send_request, send_id, query_stale, any_stale,
                  output ready);
endinterface

// File: rtl/core/heartbeat_liveness_monitor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heartbeat_liveness_monitor_unit
// Tracks heartbeats of up to four watched nodes against a millisecond clock,
// paces this node's own heartbeat and answers staleness queries.
//
//   channel  dir  handshake          carries
//   -------  ---  -----------------  -----------------------------------------
//   cmd      in   valid/ready        op, frame_id, first_byte, query_base
//   rsp      out  valid/ready        send_request, send_id, query_stale,
//                                    any_stale
//   cfg      in   cfg_wen (no wait)  cfg_index, cfg_data
//
// Every item is finished in the cycle it is accepted: the slot compares and
// the clock/send adders sit between the channel and the result register, so
// one item per cycle is sustained while rsp is not stalled. A two-deep result
// buffer (output register plus skid) lets cmd take one more item after rsp
// stalls; cmd.ready drops only while the skid entry is full. Reset (rst,
// synchronous) clears clock, stamps, send time, valid flags; config to defaults.
// ----------------------------------------------------------------------------
module heartbeat_liveness_monitor_unit
  import hlm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  hlm_cmd_if.sink               cmd,
  hlm_rsp_if.source             rsp,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  id_t             own_base;
  id_t             hb_offset;
  id_t             node_id [NODES];
  logic [MS_W-1:0] stale_limit;
  logic [MS_W-1:0] period_ms;

  // Monitor state
  ms_t now_ms, now_ms_next;
  ms_t last_send, last_send_next;
  ms_t last_seen [NODES];
  ms_t last_seen_next [NODES];

  // Result buffer
  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;
  result_t res;

  logic accept;
  id_t  self_id;
  id_t  query_id;
  ms_t  send_due;
  logic frame_ok;

  assign self_id  = own_base + hb_offset;   // 11-bit wrap
  assign query_id = cmd.query_base + hb_offset;
  assign cmd.ready = !skid_valid;
  assign accept    = cmd.valid && cmd.ready;

  assign send_due = {{(TIME_W-MS_W){1'b0}}, period_ms} + last_send;
  assign frame_ok = (cmd.frame_id != '0) && (cmd.frame_id != self_id) &&
                    (cmd.first_byte == HB_CHECK_BYTE);

  // --------------------------------------------------------------------------
  // Next state and result for the item on the cmd channel
  // --------------------------------------------------------------------------
  always_comb begin
    ms_t  expiry;
    ms_t  expiry_next;
    expiry         = '0;
    expiry_next    = '0;
    now_ms_next    = now_ms;
    last_send_next = last_send;
    for (int i = 0; i < NODES; i++) begin
      last_seen_next[i] = last_seen[i];
    end
    res = '0;

    case (cmd.op)
      OP_TICK: begin
        // Advance the clock, then fire the own heartbeat once the period passes
        now_ms_next = now_ms + 1'b1;
        if (now_ms_next > send_due) begin
          res.send_request = 1'b1;
          res.send_id      = self_id;
          last_send_next   = now_ms_next;
        end
      end
      OP_FRAME: begin
        // Stamp every slot that watches this id, if the frame passes the id and check-byte test
        for (int i = 0; i < NODES; i++) begin
          if (frame_ok && node_id[i] == cmd.frame_id) begin
            last_seen_next[i] = now_ms;
          end
        end
      end
      OP_QUERY: begin
        // Stale unless some matching slot is still inside its window
        res.query_stale = 1'b1;
        for (int i = 0; i < NODES; i++) begin
          expiry = last_seen[i] + {{(TIME_W-MS_W){1'b0}}, stale_limit};
          if (node_id[i] == query_id && now_ms < expiry) begin
            res.query_stale = 1'b0;
          end
        end
      end
      default: begin
        // Unused opcode: no state change
      end
    endcase

    // Expiry summary is taken over the state this item leaves behind
    for (int i = 0; i < NODES; i++) begin
      expiry_next = last_seen_next[i] + {{(TIME_W-MS_W){1'b0}}, stale_limit};
      if (node_id[i] != self_id && now_ms_next > expiry_next) begin
        res.any_stale = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Configuration writes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      own_base    <= '0;
      hb_offset   <= '0;
      stale_limit <= TIMEOUT_RST;
      period_ms   <= PERIOD_RST;
      for (int i = 0; i < NODES; i++) begin
        node_id[i] <= '0;
      end
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_OWN_BASE:  own_base    <= cfg_data[ID_W-1:0];
        CFG_HB_OFFSET: hb_offset   <= cfg_data[ID_W-1:0];
        CFG_TIMEOUT:   stale_limit <= cfg_data[MS_W-1:0];
        CFG_PERIOD:    period_ms   <= cfg_data[MS_W-1:0];
        default: begin
          // Slot identifiers occupy consecutive indexes
          for (int i = 0; i < NODES; i++) begin
            if (cfg_index == CFG_NODE_ID_0 + CFG_IDX_W'(i)) begin
              node_id[i] <= cfg_data[ID_W-1:0];
            end
          end
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // State update on accept
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms    <= '0;
      last_send <= '0;
      for (int i = 0; i < NODES; i++) begin
        last_seen[i] <= '0;
      end
    end else if (accept) begin
      now_ms    <= now_ms_next;
      last_send <= last_send_next;
      for (int i = 0; i < NODES; i++) begin
        last_seen[i] <= last_seen_next[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register with skid entry
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (accept) begin
      // skid is empty here, since cmd.ready requires it
      if (!out_valid || rsp.ready) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_valid && rsp.ready) begin
      // Drain skid into the output, or drop valid
      out_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!out_valid || rsp.ready) begin
        out_data <= res;
      end else begin
        skid_data <= res;
      end
    end else if (out_valid && rsp.ready && skid_valid) begin
      out_data <= skid_data;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.send_request = out_data.send_request;
  assign rsp.send_id      = out_data.send_id;
  assign rsp.query_stale  = out_data.query_stale;
  assign rsp.any_stale    = out_data.any_stale;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register empty");

  a_tick_advances: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.op == OP_TICK |=> now_ms == $past(now_ms) + 1'b1)
    else $error("tick did not advance the clock");

  a_nontick_holds: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.op != OP_TICK |=> $stable(now_ms) && $stable(last_send))
    else $error("clock or send time moved without a tick");

  a_quiet_send_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.send_request |-> out_data.send_id == '0)
    else $error("send id set without send request");

endmodule
